>>> hw/rtl/rnft_pkg.sv
// Shared types, codes and constants for the RSSI noise floor tracker.
`timescale 1ns / 1ps

package rnft_pkg;

    // Default number of samples averaged into one floor estimate.
    localparam int SAMPLE_COUNT_DEF = 64;

    // Configuration port widths and reset values.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [6:0]        MARGIN_RST    = 7'd14;
    localparam logic signed [7:0] FLOOR_MIN_RST = -8'sd120;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_MARGIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_MINIMUM = 1'b1;

    // Action codes carried by each input item.
    typedef enum logic [1:0] {
        ACT_TICK      = 2'd0,
        ACT_CALIBRATE = 2'd1,
        ACT_AGC_RESET = 2'd2
    } action_t;

    // One input item.
    typedef struct packed {
        logic [1:0]         action;
        logic signed [7:0]  rssi;
        logic               preamble_seen;
        logic               header_valid;
        logic               rx_done;
        logic               tx_done;
        logic               tx_waiting;
        logic signed [15:0] new_threshold;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic signed [7:0] noise_floor;
        logic              channel_busy;
        logic              sampling_active;
        logic [6:0]        samples_taken;
        logic              agc_reset_done;
    } out_item_t;

    // Current configuration register contents.
    typedef struct packed {
        logic [6:0]        sample_margin;
        logic signed [7:0] floor_minimum;
    } cfg_t;

endpackage

>>> hw/rtl/rnft_cfg_regs.sv
// Configuration registers of the RSSI noise floor tracker.
`timescale 1ns / 1ps

module rnft_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              wr_en,
    input  logic [rnft_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [rnft_pkg::CFG_DATA_W-1:0]   wr_data,
    output rnft_pkg::cfg_t                    cfg
);

    logic [6:0]        margin_reg;
    logic signed [7:0] floor_min_reg;

    // Register write decode.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            margin_reg    <= rnft_pkg::MARGIN_RST;
            floor_min_reg <= rnft_pkg::FLOOR_MIN_RST;
        end else if (wr_en) begin
            unique case (wr_index)
                rnft_pkg::CFG_SAMPLE_MARGIN: margin_reg    <= wr_data[6:0];
                rnft_pkg::CFG_FLOOR_MINIMUM: floor_min_reg <= signed'(wr_data[7:0]);
                default: ;
            endcase
        end
    end

    assign cfg.sample_margin = margin_reg;
    assign cfg.floor_minimum = floor_min_reg;

endmodule

>>> hw/rtl/rnft_avg_unit.sv
// Averaging unit: sum divided by the sample count, truncated toward zero and clamped.
`timescale 1ns / 1ps

module rnft_avg_unit #(
    parameter int SAMPLE_COUNT = rnft_pkg::SAMPLE_COUNT_DEF
) (
    input  logic signed [$clog2(SAMPLE_COUNT)+7:0] sum,
    input  logic signed [7:0]                      floor_min,
    output logic signed [7:0]                      avg
);

    localparam int L    = $clog2(SAMPLE_COUNT);
    localparam int SW   = L + 8;
    localparam int DIVK = SW + L;
    localparam int RW   = SW + 2;
    localparam int PW   = SW + RW;
    // Reciprocal scaled by 2^DIVK, rounded up; exact for every magnitude below 2^SW.
    localparam logic [RW-1:0] RECIP =
        RW'(((64'd1 << DIVK) + 64'(SAMPLE_COUNT) - 64'd1) / 64'(SAMPLE_COUNT));

    logic              neg;
    logic [SW-1:0]     mag;
    logic [PW-1:0]     prod;
    logic [8:0]        quot;
    logic signed [8:0] quot_s;
    logic signed [8:0] avg9;
    logic signed [8:0] min9;

    // Divide the magnitude by multiplying with the reciprocal, then restore the sign.
    always_comb begin
        neg    = sum[SW-1];
        mag    = neg ? (~unsigned'(sum) + 1'b1) : unsigned'(sum);
        prod   = PW'(mag) * PW'(RECIP);
        quot   = 9'(prod >> DIVK);
        quot_s = signed'(quot);
        avg9   = neg ? -quot_s : quot_s;
        min9   = {floor_min[7], floor_min};
        avg    = (avg9 < min9) ? floor_min : avg9[7:0];
    end

endmodule

>>> hw/rtl/rnft_core.sv
// Tracker state and the per-item update of floor, threshold and sampling run.
`timescale 1ns / 1ps

module rnft_core #(
    parameter int SAMPLE_COUNT = rnft_pkg::SAMPLE_COUNT_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  rnft_pkg::in_item_t   item,
    input  rnft_pkg::cfg_t       cfg,
    output rnft_pkg::out_item_t  result
);

    localparam int SW = $clog2(SAMPLE_COUNT) + 8;
    localparam int CW = $clog2(SAMPLE_COUNT + 1);
    localparam logic [CW-1:0] COUNT_FULL = CW'(SAMPLE_COUNT);

    logic signed [7:0]  floor_reg, floor_next;
    logic signed [15:0] thr_reg, thr_next;
    logic [CW-1:0]      count_reg, count_next;
    logic signed [SW-1:0] sum_reg, sum_next;

    logic               packet;
    logic               flags_pending;
    logic               full;
    logic               below;
    logic               busy;
    logic               agc_ok;
    logic signed [16:0] busy_lim;
    logic signed [9:0]  samp_lim;
    logic signed [7:0]  avg;

    rnft_avg_unit #(
        .SAMPLE_COUNT(SAMPLE_COUNT)
    ) u_avg (
        .sum       (sum_reg),
        .floor_min (cfg.floor_minimum),
        .avg       (avg)
    );

    // Channel busy and sampling window, both from the state before the item.
    always_comb begin
        packet        = item.preamble_seen | item.header_valid;
        flags_pending = packet | item.rx_done | item.tx_done;
        full          = (count_reg >= COUNT_FULL);
        busy_lim      = {{9{floor_reg[7]}}, floor_reg} + {thr_reg[15], thr_reg};
        busy          = packet ||
                        ((thr_reg != 16'sd0) &&
                         (signed'({{9{item.rssi[7]}}, item.rssi}) > busy_lim));
        samp_lim      = {{2{floor_reg[7]}}, floor_reg} + signed'({3'b000, cfg.sample_margin});
        below         = (signed'({{2{item.rssi[7]}}, item.rssi}) < samp_lim);
    end

    // Next state for each action.
    always_comb begin
        floor_next = floor_reg;
        thr_next   = thr_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        agc_ok     = 1'b0;
        case (item.action)
            rnft_pkg::ACT_TICK: begin
                if (!item.tx_waiting && !full) begin
                    if (!packet && below) begin
                        count_next = count_reg + 1'b1;
                        sum_next   = sum_reg + {{(SW-8){item.rssi[7]}}, item.rssi};
                    end
                end else if (full && (sum_reg != '0)) begin
                    floor_next = avg;
                    sum_next   = '0;
                end
            end
            rnft_pkg::ACT_CALIBRATE: begin
                thr_next = item.new_threshold;
                if (full) begin
                    count_next = '0;
                    sum_next   = '0;
                end
            end
            rnft_pkg::ACT_AGC_RESET: begin
                if (!flags_pending) begin
                    floor_next = '0;
                    count_next = '0;
                    sum_next   = '0;
                    agc_ok     = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Result reflects the state after the item.
    always_comb begin
        result.noise_floor     = floor_next;
        result.channel_busy    = busy;
        result.sampling_active = (count_next < COUNT_FULL);
        result.samples_taken   = 7'(count_next);
        result.agc_reset_done  = agc_ok;
    end

    // State registers advance once per item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            floor_reg <= '0;
            thr_reg   <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
        end else if (step) begin
            floor_reg <= floor_next;
            thr_reg   <= thr_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

endmodule

>>> hw/rtl/rssi_noise_floor_tracker_unit.sv
// Top level of the RSSI noise floor tracker: input register, core and result register.
//
//   Channel   Direction  Handshake            Payload
//   s_        in         s_valid / s_ready    s_item   (rnft_pkg::in_item_t)
//   m_        out        m_valid / m_ready    m_item   (rnft_pkg::out_item_t)
//   cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item per cycle sustained while m_ready stays high; each item is held in the input
// register, and its result from the combinational core update goes into the result register.
// Reset is synchronous; there is no clearing pass.
// While the result register is held by m_ready low, one more item is taken into the
// input register, then s_ready drops. Configuration writes are always accepted.
`timescale 1ns / 1ps

module rssi_noise_floor_tracker_unit #(
    parameter int SAMPLE_COUNT = rnft_pkg::SAMPLE_COUNT_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  rnft_pkg::in_item_t              s_item,
    output logic                            m_valid,
    input  logic                            m_ready,
    output rnft_pkg::out_item_t             m_item,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rnft_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rnft_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic                in_valid_reg;
    rnft_pkg::in_item_t  in_item_reg;
    logic                out_valid_reg;
    rnft_pkg::out_item_t out_item_reg;
    rnft_pkg::cfg_t      cfg;
    rnft_pkg::out_item_t result;
    logic                advance;
    logic                s_take;

    assign cfg_ready = 1'b1;

    rnft_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    rnft_core #(
        .SAMPLE_COUNT(SAMPLE_COUNT)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // The held item moves on whenever the result register is free or being emptied.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_take  = s_valid && s_ready;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_take) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_item_reg <= s_item;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_item_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

endmodule

>>> hw/rtl/rnft_checker.sv
// Port-level checks for the RSSI noise floor tracker and their binding.
`timescale 1ns / 1ps

module rnft_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input rnft_pkg::out_item_t             m_item
);

    // A stalled result item stays put.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result item changed while stalled");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A free or draining output never throttles the input.
    a_full_rate: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_ready || !m_valid) |-> s_ready)
        else $error("input stalled with output free");

    // An accepted AGC reset leaves an empty run and a zero floor.
    a_agc_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.agc_reset_done |->
            (m_item.noise_floor == 8'sd0) && (m_item.samples_taken == 7'd0) &&
            m_item.sampling_active)
        else $error("AGC reset did not clear the run");

endmodule

bind rssi_noise_floor_tracker_unit rnft_checker u_rnft_checker (.*);

>>> bench/tb_rssi_noise_floor_tracker_unit.sv
// Self-checking testbench for the RSSI noise floor tracker with directed and random items.
`timescale 1ns / 1ps

module tb_rssi_noise_floor_tracker_unit;

    localparam int SAMPLES      = rnft_pkg::SAMPLE_COUNT_DEF;
    localparam int QUIET_LIMIT  = 2000;
    localparam int PHASE_ITEMS  = 150;
    localparam int NUM_PHASES   = 8;
    localparam int DRAIN_CYCLES = 10;

    // Action code that the block must ignore.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // Flag groups, ordered preamble, header, rx done, tx done, tx waiting.
    localparam logic [4:0] FL_NONE = 5'b00000;
    localparam logic [4:0] FL_PRE  = 5'b10000;
    localparam logic [4:0] FL_HDR  = 5'b01000;
    localparam logic [4:0] FL_RXD  = 5'b00100;
    localparam logic [4:0] FL_TXD  = 5'b00010;
    localparam logic [4:0] FL_TXW  = 5'b00001;
    localparam logic [4:0] FL_ALL  = 5'b11111;

    // One row of the directed table.
    typedef struct packed {
        rnft_pkg::in_item_t  item;
        logic                typed;
        rnft_pkg::out_item_t report;
    } dir_row_t;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_valid;
    logic                            s_ready;
    rnft_pkg::in_item_t              s_item;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    rnft_pkg::out_item_t             m_item;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [rnft_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [rnft_pkg::CFG_DATA_W-1:0] cfg_data;

    // Shadow copy of the tracker state and its registers.
    int floor_est     = 0;
    int busy_thr      = 0;
    int run_count     = 0;
    int run_sum       = 0;
    int margin_reg    = rnft_pkg::MARGIN_RST;
    int floor_min_reg = rnft_pkg::FLOOR_MIN_RST;

    rnft_pkg::out_item_t floor_reports[$];
    dir_row_t            dir_rows[$];
    rnft_pkg::out_item_t want_report;

    int  mismatch_count = 0;
    int  items_sent     = 0;
    int  quiet_cycles   = 0;
    int  cyc_count      = 0;
    int  stall_mode     = 0;
    int  burst_left     = 0;
    bit  s_hold         = 0;

    rssi_noise_floor_tracker_unit #(
        .SAMPLE_COUNT(SAMPLES)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Free-running 100 MHz clock.
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Builds one input item from its fields.
    function automatic rnft_pkg::in_item_t mk_item(logic [1:0] act, int rssi, logic [4:0] fl,
                                                   int thr);
        rnft_pkg::in_item_t it;
        it.action        = act;
        it.rssi          = rssi[7:0];
        it.preamble_seen = fl[4];
        it.header_valid  = fl[3];
        it.rx_done       = fl[2];
        it.tx_done       = fl[1];
        it.tx_waiting    = fl[0];
        it.new_threshold = thr[15:0];
        return it;
    endfunction

    // Builds one result item from its fields.
    function automatic rnft_pkg::out_item_t mk_report(int nf, int busy, int act, int taken,
                                                      int agc);
        rnft_pkg::out_item_t r;
        r.noise_floor     = nf[7:0];
        r.channel_busy    = busy[0];
        r.sampling_active = act[0];
        r.samples_taken   = taken[6:0];
        r.agc_reset_done  = agc[0];
        return r;
    endfunction

    // Advances the shadow tracker by one item and returns the result it causes.
    function automatic rnft_pkg::out_item_t advance_tracker(rnft_pkg::in_item_t it);
        rnft_pkg::out_item_t rep;
        int        r;
        int        avg;
        bit        pkt;
        bit        busy;
        bit        agc_ok;
        r      = $signed(it.rssi);
        pkt    = it.preamble_seen || it.header_valid;
        busy   = pkt || (busy_thr != 0 && r > floor_est + busy_thr);
        agc_ok = 1'b0;
        case (it.action)
            rnft_pkg::ACT_TICK: begin
                if (!it.tx_waiting && run_count < SAMPLES) begin
                    if (!pkt && r < floor_est + margin_reg) begin
                        run_count++;
                        run_sum += r;
                    end
                end else if (run_count >= SAMPLES && run_sum != 0) begin
                    // Average truncates toward zero, then clamps at the minimum.
                    avg = run_sum / SAMPLES;
                    if (avg < floor_min_reg)
                        avg = floor_min_reg;
                    floor_est = avg;
                    run_sum   = 0;
                end
            end
            rnft_pkg::ACT_CALIBRATE: begin
                busy_thr = $signed(it.new_threshold);
                if (run_count >= SAMPLES) begin
                    run_count = 0;
                    run_sum   = 0;
                end
            end
            rnft_pkg::ACT_AGC_RESET: begin
                if (!(it.rx_done || it.tx_done || pkt)) begin
                    floor_est = 0;
                    run_count = 0;
                    run_sum   = 0;
                    agc_ok    = 1'b1;
                end
            end
            default: ;
        endcase
        rep.noise_floor     = floor_est[7:0];
        rep.channel_busy    = busy;
        rep.sampling_active = (run_count < SAMPLES);
        rep.samples_taken   = run_count[6:0];
        rep.agc_reset_done  = agc_ok;
        return rep;
    endfunction

    // Random busy threshold, weighted toward zero and small values.
    function automatic int rand_threshold();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return $urandom_range(0, 40);
            2:       return -int'($urandom_range(0, 200));
            default: return $urandom_range(0, 65535);
        endcase
    endfunction

    // Presents one item, waits for it to be taken, and records its result.
    // A typed row pushes its written-out result instead of the predicted one.
    task automatic send_item(rnft_pkg::in_item_t it, logic typed, rnft_pkg::out_item_t fixed);
        rnft_pkg::out_item_t rep;
        s_item  <= it;
        s_valid <= 1'b1;
        s_hold   = 1'b1;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        rep = advance_tracker(it);
        floor_reports.push_back(typed ? fixed : rep);
        items_sent++;
        // Bursts of random length, separated by random gaps.
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid <= 1'b0;
            s_hold   = 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 12);
        end
    endtask

    // Stops the sender and waits until every pending result has come back.
    task automatic drain_results();
        if (s_hold) begin
            s_valid <= 1'b0;
            s_hold   = 1'b0;
        end
        while (floor_reports.size() != 0)
            @(posedge aclk);
    endtask

    // Writes one register; cfg_valid is left high for a following write.
    task automatic write_reg(logic [rnft_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        if (idx == rnft_pkg::CFG_SAMPLE_MARGIN)
            margin_reg = val[6:0];
        else
            floor_min_reg = $signed(val);
    endtask

    // Sends a clean AGC reset, which always succeeds.
    task automatic agc_clean();
        send_item(mk_item(rnft_pkg::ACT_AGC_RESET, $urandom_range(0, 255), FL_NONE,
                          rand_threshold()), 1'b0, '0);
    endtask

    // A sampling run with random content; a full run is closed by one or more ending ticks.
    task automatic fill_run();
        int tries;
        int lim;
        int lo;
        int r;
        if (run_count >= SAMPLES || $urandom_range(0, 3) == 0) begin
            if ($urandom_range(0, 1))
                send_item(mk_item(rnft_pkg::ACT_CALIBRATE, $urandom_range(0, 255),
                                  5'($urandom_range(0, 31)), rand_threshold()), 1'b0, '0);
            else
                agc_clean();
        end
        tries = 0;
        while (run_count < SAMPLES && tries < 4 * SAMPLES) begin
            tries++;
            lim = floor_est + margin_reg - 1;
            if (lim > 127)
                lim = 127;
            if (lim < -128 || $urandom_range(0, 9) == 0) begin
                send_item(mk_item(rnft_pkg::ACT_TICK, $urandom_range(0, 255),
                                  5'($urandom_range(0, 31)), rand_threshold()), 1'b0, '0);
            end else begin
                lo = $urandom_range(0, 1) ? -128 : lim - 24;
                if (lo < -128)
                    lo = -128;
                r = lo + $urandom_range(0, lim - lo);
                send_item(mk_item(rnft_pkg::ACT_TICK, r, FL_NONE, rand_threshold()),
                          1'b0, '0);
            end
        end
        // A floor at the bottom with no margin can never sample; start over.
        if (run_count < SAMPLES) begin
            agc_clean();
        end else begin
            repeat ($urandom_range(1, 3))
                send_item(mk_item(rnft_pkg::ACT_TICK, $urandom_range(0, 255),
                                  $urandom_range(0, 1) ? FL_TXW : 5'($urandom_range(0, 31)),
                                  rand_threshold()), 1'b0, '0);
        end
    endtask

    // A run whose samples cancel out, so the average is skipped.
    task automatic zero_sum_run();
        int k;
        agc_clean();
        if (margin_reg > 0) begin
            while (run_count < SAMPLES) begin
                k = $urandom_range(0, margin_reg - 1);
                send_item(mk_item(rnft_pkg::ACT_TICK, k, FL_NONE, 0), 1'b0, '0);
                send_item(mk_item(rnft_pkg::ACT_TICK, -k, FL_NONE, 0), 1'b0, '0);
            end
            repeat ($urandom_range(1, 2))
                send_item(mk_item(rnft_pkg::ACT_TICK, $urandom_range(0, 255), FL_NONE, 0),
                          1'b0, '0);
        end
    endtask

    // Fully random items of every action, the unused one included.
    task automatic noise_burst();
        repeat ($urandom_range(5, 20))
            send_item(mk_item(2'($urandom_range(0, 3)), $urandom_range(0, 255),
                              5'($urandom_range(0, 31)), $urandom_range(0, 65535)),
                      1'b0, '0);
    endtask

    // New threshold, then ticks with RSSI right around floor plus threshold.
    task automatic busy_probe();
        int r;
        send_item(mk_item(rnft_pkg::ACT_CALIBRATE, $urandom_range(0, 255), FL_NONE,
                          rand_threshold()), 1'b0, '0);
        repeat (6) begin
            r = floor_est + busy_thr + $urandom_range(0, 4) - 2;
            if (r > 127)
                r = 127;
            if (r < -128)
                r = -128;
            send_item(mk_item(rnft_pkg::ACT_TICK, r,
                              ($urandom_range(0, 3) == 0) ? FL_PRE : FL_NONE, 0), 1'b0, '0);
        end
    endtask

    // Result checking, plus the receiver's own stall pattern.
    always @(posedge aclk) begin
        cyc_count++;
        if (aresetn && m_valid && m_ready) begin
            if (floor_reports.size() == 0) begin
                $error("result item arrived with nothing pending: %h", m_item);
                mismatch_count++;
            end else begin
                want_report = floor_reports.pop_front();
                if (m_item.noise_floor !== want_report.noise_floor) begin
                    $error("noise_floor: expected %0d, got %0d",
                           want_report.noise_floor, m_item.noise_floor);
                    mismatch_count++;
                end
                if (m_item.channel_busy !== want_report.channel_busy) begin
                    $error("channel_busy: expected %0d, got %0d",
                           want_report.channel_busy, m_item.channel_busy);
                    mismatch_count++;
                end
                if (m_item.sampling_active !== want_report.sampling_active) begin
                    $error("sampling_active: expected %0d, got %0d",
                           want_report.sampling_active, m_item.sampling_active);
                    mismatch_count++;
                end
                if (m_item.samples_taken !== want_report.samples_taken) begin
                    $error("samples_taken: expected %0d, got %0d",
                           want_report.samples_taken, m_item.samples_taken);
                    mismatch_count++;
                end
                if (m_item.agc_reset_done !== want_report.agc_reset_done) begin
                    $error("agc_reset_done: expected %0d, got %0d",
                           want_report.agc_reset_done, m_item.agc_reset_done);
                    mismatch_count++;
                end
            end
        end
        if (cyc_count % 256 == 0)
            stall_mode = $urandom_range(0, 3);
        case (stall_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= $urandom_range(0, 1);
            2:       m_ready <= (cyc_count % 7) < 3;
            default: m_ready <= (cyc_count % 9) == 0;
        endcase
    end

    // Watchdog on cycles in which no channel moves an item.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_rssi_noise_floor_tracker_unit failed");
            $finish;
        end
    end

    // Main sequence: reset, directed table, then random phases per setting.
    initial begin
        logic [7:0] margin_byte;
        logic [7:0] fmin_byte;
        int         phase_start;
        int         kind;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_item    <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table, run with the registers at their reset values.
        dir_rows.push_back({mk_item(rnft_pkg::ACT_TICK, -128, FL_NONE, 0), 1'b1,
                            mk_report(0, 0, 1, 1, 0)});
        dir_rows.push_back({mk_item(rnft_pkg::ACT_TICK, 127, FL_NONE, 0), 1'b1,
                            mk_report(0, 0, 1, 1, 0)});
        dir_rows.push_back({mk_item(rnft_pkg::ACT_TICK, -50, FL_PRE, 0), 1'b1,
                            mk_report(0, 1, 1, 1, 0)});
        dir_rows.push_back({mk_item(rnft_pkg::ACT_TICK, -50, FL_HDR, 0), 1'b1,
                            mk_report(0, 1, 1, 1, 0)});
        dir_rows.push_back({mk_item(rnft_pkg::ACT_TICK, -100, FL_TXW, 0), 1'b1,
                            mk_report(0, 0, 1, 1, 0)});
        // AGC reset is refused while a preamble, header, rx done or tx done flag is pending.
        dir_rows.push_back({mk_item(rnft_pkg::ACT_AGC_RESET, -60, FL_RXD, 0), 1'b1,
                            mk_report(0, 0, 1, 1, 0)});
        dir_rows.push_back({mk_item(rnft_pkg::ACT_AGC_RESET, -60, FL_TXD, 0), 1'b1,
                            mk_report(0, 0, 1, 1, 0)});
        dir_rows.push_back({mk_item(rnft_pkg::ACT_AGC_RESET, -60, FL_PRE, 0), 1'b1,
                            mk_report(0, 1, 1, 1, 0)});
        dir_rows.push_back({mk_item(rnft_pkg::ACT_AGC_RESET, -60, FL_HDR, 0), 1'b1,
                            mk_report(0, 1, 1, 1, 0)});
        dir_rows.push_back({mk_item(rnft_pkg::ACT_AGC_RESET, -60, FL_NONE, 0), 1'b1,
                            mk_report(0, 0, 1, 0, 1)});
        // The unused action leaves the state alone but still reports.
        dir_rows.push_back({mk_item(ACT_UNUSED, -1, FL_ALL, 32767), 1'b1,
                            mk_report(0, 1, 1, 0, 0)});
        // Threshold extremes; busy always uses the threshold held before the item.
        dir_rows.push_back({mk_item(rnft_pkg::ACT_CALIBRATE, -10, FL_NONE, -32768), 1'b1,
                            mk_report(0, 0, 1, 0, 0)});
        dir_rows.push_back({mk_item(rnft_pkg::ACT_TICK, 0, FL_NONE, 0), 1'b1,
                            mk_report(0, 1, 1, 1, 0)});
        dir_rows.push_back({mk_item(rnft_pkg::ACT_CALIBRATE, -128, FL_NONE, 32767), 1'b1,
                            mk_report(0, 1, 1, 1, 0)});
        dir_rows.push_back({mk_item(rnft_pkg::ACT_TICK, 127, FL_NONE, 0), 1'b1,
                            mk_report(0, 0, 1, 1, 0)});
        dir_rows.push_back({mk_item(rnft_pkg::ACT_CALIBRATE, 0, FL_NONE, 1), 1'b1,
                            mk_report(0, 0, 1, 1, 0)});
        // RSSI at and around the busy and margin boundaries.
        dir_rows.push_back({mk_item(rnft_pkg::ACT_TICK, 2, FL_NONE, 0), 1'b1,
                            mk_report(0, 1, 1, 2, 0)});
        dir_rows.push_back({mk_item(rnft_pkg::ACT_TICK, 1, FL_NONE, 0), 1'b1,
                            mk_report(0, 0, 1, 3, 0)});
        dir_rows.push_back({mk_item(rnft_pkg::ACT_TICK, 13, FL_NONE, 0), 1'b1,
                            mk_report(0, 1, 1, 4, 0)});
        dir_rows.push_back({mk_item(rnft_pkg::ACT_TICK, 14, FL_NONE, 0), 1'b1,
                            mk_report(0, 1, 1, 4, 0)});
        // Rx and tx done flags do not block sampling.
        dir_rows.push_back({mk_item(rnft_pkg::ACT_TICK, -128, FL_RXD | FL_TXD, 0), 1'b1,
                            mk_report(0, 0, 1, 5, 0)});
        dir_rows.push_back({mk_item(rnft_pkg::ACT_CALIBRATE, -5, FL_NONE, 0), 1'b0,
                            rnft_pkg::out_item_t'('0)});
        dir_rows.push_back({mk_item(rnft_pkg::ACT_AGC_RESET, -5, FL_NONE, 0), 1'b0,
                            rnft_pkg::out_item_t'('0)});
        foreach (dir_rows[i])
            send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].report);

        // Random phases, each under its own register setting.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            drain_results();
            case (phase)
                0: begin margin_byte = 8'd14;  fmin_byte = 8'(-120); end
                1: begin margin_byte = 8'd127; fmin_byte = 8'h80;    end
                2: begin margin_byte = 8'd0;   fmin_byte = 8'h00;    end
                3: begin margin_byte = 8'hFF;  fmin_byte = 8'(-60);  end
                4: begin margin_byte = 8'd40;  fmin_byte = 8'h7F;    end
                default: begin
                    margin_byte = $urandom_range(0, 255);
                    fmin_byte   = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                                               : 8'(-$urandom_range(0, 128));
                end
            endcase
            write_reg(rnft_pkg::CFG_SAMPLE_MARGIN, margin_byte);
            write_reg(rnft_pkg::CFG_FLOOR_MINIMUM, fmin_byte);
            cfg_valid <= 1'b0;
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                kind = $urandom_range(0, 9);
                if (kind <= 5)
                    fill_run();
                else if (kind == 6)
                    zero_sum_run();
                else if (kind <= 8)
                    noise_burst();
                else
                    busy_probe();
            end
        end

        // Let everything come back, then idle for DRAIN_CYCLES to catch strays.
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && floor_reports.size() == 0)
            $display("tb_rssi_noise_floor_tracker_unit passed");
        else
            $display("tb_rssi_noise_floor_tracker_unit failed");
        $finish;
    end

endmodule
